### src/packed_yuv_to_xbgr_pixels_macros.svh
// Assertion macros for the packed YUV to XBGR pixel converter.
// Used by the checker module; depends on nothing else.
`ifndef PACKED_YUV_TO_XBGR_PIXELS_MACROS_SVH
`define PACKED_YUV_TO_XBGR_PIXELS_MACROS_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low.
`define PYX_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off while arst_n is low.
`define PYX_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### src/pyx_pkg.sv
// Shared types, register codes and matrix constants for the packed YUV to XBGR converter.
// Depends on nothing; every other file but the macros header refers to it by scoped names.
package pyx_pkg;

	localparam int COEF_FRACTION_BITS_DEF = 15;
	localparam int QUEUE_DEPTH_DEF = 4;

	localparam int CFG_W = 2;
	localparam int CFG_INDEX_W = 2;

	localparam logic [CFG_INDEX_W-1:0] REG_MATRIX_STANDARD = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_INPUT_PACKING = 2'd1;

	localparam logic [CFG_W-1:0] STD_FULL = 2'd0;
	localparam logic [CFG_W-1:0] STD_SDTV = 2'd1;
	localparam logic [CFG_W-1:0] STD_HDTV = 2'd2;

	localparam logic [CFG_W-1:0] PACK_YUY2 = 2'd0;
	localparam logic [CFG_W-1:0] PACK_UYVY = 2'd1;
	localparam logic [CFG_W-1:0] PACK_AYUV = 2'd2;

	localparam logic [CFG_W-1:0] MATRIX_STANDARD_RST = STD_SDTV;
	localparam logic [CFG_W-1:0] INPUT_PACKING_RST = PACK_YUY2;

	// Columns of the matrix table: Y offset, then coefficients in thousandths.
	localparam int COL_YOFF = 0;
	localparam int COL_Y = 1;
	localparam int COL_RV = 2;
	localparam int COL_GU = 3;
	localparam int COL_GV = 4;
	localparam int COL_BU = 5;

	localparam int MAT_MILLI [3][6] = '{
		'{0, 1000, 1400, -343, -711, 1765},
		'{16, 1164, 1596, -391, -813, 2018},
		'{16, 1164, 1793, -213, -533, 2112}
	};

	typedef struct packed {
		logic [CFG_W-1:0] matrix_standard;
		logic [CFG_W-1:0] input_packing;
	} cfg_t;

	typedef struct packed {
		logic [7:0] byte_0;
		logic [7:0] byte_1;
		logic [7:0] byte_2;
		logic [7:0] byte_3;
		logic       last_in_frame;
	} in_item_t;

	typedef struct packed {
		logic [7:0] blue;
		logic [7:0] green;
		logic [7:0] red;
		logic [7:0] alpha;
		logic       last_of_word;
		logic       frame_end;
	} out_item_t;

	typedef struct packed {
		logic [7:0] y;
		logic [7:0] u;
		logic [7:0] v;
		logic       last_of_word;
		logic       frame_end;
	} pix_job_t;

	// Coefficient in thousandths scaled by 2^fb, rounded half away from zero.
	// Only called with constants, at elaboration.
	function automatic longint coef_scaled(input int milli, input int fb);
		longint mag;
		longint q;
		mag = (milli < 0) ? -longint'(milli) : longint'(milli);
		q = ((mag << fb) + 64'sd500) / 64'sd1000;
		return (milli < 0) ? -q : q;
	endfunction

endpackage

### src/pyx_front.sv
// Front end: accepts packed words and splits each one into one or two pixel jobs.
// Depends on pyx_pkg; feeds pyx_queue.
module pyx_front (
	input  logic             clk,
	input  logic             arst_n,
	input  pyx_pkg::cfg_t    cfg,
	input  logic             in_valid,
	output logic             in_ready,
	input  pyx_pkg::in_item_t in_data,
	input  logic             q_full,
	output logic             push,
	output pyx_pkg::pix_job_t job
);

	pyx_pkg::in_item_t word_q;
	logic word_valid_q;
	logic second_q;
	logic done;

	always_comb begin
		job = '0;
		case (cfg.input_packing)
			pyx_pkg::PACK_AYUV: begin
				job.y = word_q.byte_2;
				job.u = word_q.byte_1;
				job.v = word_q.byte_0;
				job.last_of_word = 1'b1;
				job.frame_end = word_q.last_in_frame;
			end
			pyx_pkg::PACK_UYVY: begin
				job.y = second_q ? word_q.byte_3 : word_q.byte_1;
				job.u = word_q.byte_0;
				job.v = word_q.byte_2;
				job.last_of_word = second_q;
				job.frame_end = second_q & word_q.last_in_frame;
			end
			default: begin
				job.y = second_q ? word_q.byte_2 : word_q.byte_0;
				job.u = word_q.byte_1;
				job.v = word_q.byte_3;
				job.last_of_word = second_q;
				job.frame_end = second_q & word_q.last_in_frame;
			end
		endcase
	end

	assign push = word_valid_q & ~q_full;
	assign done = push & job.last_of_word;
	assign in_ready = ~word_valid_q | done;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			word_valid_q <= 1'b0;
			second_q <= 1'b0;
		end else if (in_valid && in_ready) begin
			word_valid_q <= 1'b1;
			second_q <= 1'b0;
		end else if (done) begin
			word_valid_q <= 1'b0;
			second_q <= 1'b0;
		end else if (push) begin
			second_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			word_q <= in_data;
		end
	end

endmodule

### src/pyx_queue.sv
// Short queue of pixel jobs between the front end and the matrix pipeline.
// Depends on pyx_pkg.
module pyx_queue #(
	parameter int DEPTH = pyx_pkg::QUEUE_DEPTH_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  pyx_pkg::pix_job_t push_job,
	input  logic              pop,
	output logic              full,
	output logic              empty,
	output pyx_pkg::pix_job_t head
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);

	pyx_pkg::pix_job_t entries_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic do_push;
	logic do_pop;

	assign full = (count_q == CNT_W'(DEPTH));
	assign empty = (count_q == '0);
	assign do_push = push & ~full;
	assign do_pop = pop & ~empty;
	assign head = entries_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({do_push, do_pop})
				2'b10: count_q <= count_q + 1'b1;
				2'b01: count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			entries_q[wr_ptr_q] <= push_job;
		end
	end

endmodule

### src/pyx_back.sv
// Back end: two-stage YUV to RGB matrix, rounding and clamping; one pixel per cycle unless stalled.
// Depends on pyx_pkg; drains pyx_queue and drives the result port.
module pyx_back #(
	parameter int COEF_FRACTION_BITS = pyx_pkg::COEF_FRACTION_BITS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  pyx_pkg::cfg_t      cfg,
	input  logic               q_empty,
	input  pyx_pkg::pix_job_t  head,
	output logic               pop,
	output logic               out_valid,
	input  logic               out_ready,
	output pyx_pkg::out_item_t out_data
);

	localparam int FB = COEF_FRACTION_BITS;
	localparam int COEF_W = FB + 3;
	localparam int PW = COEF_W + 10;
	localparam int SW = PW + 2;
	localparam logic signed [SW-1:0] RND = SW'(1) << (FB - 1);

	typedef struct packed {
		logic [4:0]               yoff;
		logic signed [COEF_W-1:0] y;
		logic signed [COEF_W-1:0] rv;
		logic signed [COEF_W-1:0] gu;
		logic signed [COEF_W-1:0] gv;
		logic signed [COEF_W-1:0] bu;
	} coef_set_t;

	function automatic coef_set_t make_set(input int s);
		coef_set_t c;
		c.yoff = 5'(pyx_pkg::MAT_MILLI[s][pyx_pkg::COL_YOFF]);
		c.y = COEF_W'(pyx_pkg::coef_scaled(pyx_pkg::MAT_MILLI[s][pyx_pkg::COL_Y], FB));
		c.rv = COEF_W'(pyx_pkg::coef_scaled(pyx_pkg::MAT_MILLI[s][pyx_pkg::COL_RV], FB));
		c.gu = COEF_W'(pyx_pkg::coef_scaled(pyx_pkg::MAT_MILLI[s][pyx_pkg::COL_GU], FB));
		c.gv = COEF_W'(pyx_pkg::coef_scaled(pyx_pkg::MAT_MILLI[s][pyx_pkg::COL_GV], FB));
		c.bu = COEF_W'(pyx_pkg::coef_scaled(pyx_pkg::MAT_MILLI[s][pyx_pkg::COL_BU], FB));
		return c;
	endfunction

	function automatic logic [7:0] clamp8(input logic signed [SW-1:0] t);
		logic signed [SW-1:0] sh;
		sh = t >>> FB;
		if (t[SW-1]) begin
			return 8'h00;
		end else if (sh > $signed(SW'(255))) begin
			return 8'hFF;
		end else begin
			return sh[7:0];
		end
	endfunction

	localparam coef_set_t SET_FULL = make_set(0);
	localparam coef_set_t SET_SDTV = make_set(1);
	localparam coef_set_t SET_HDTV = make_set(2);

	coef_set_t cs;
	logic en;
	logic signed [9:0] yd;
	logic signed [8:0] ud;
	logic signed [8:0] vd;

	logic valid_s1;
	logic signed [PW-1:0] ty_s1;
	logic signed [PW-1:0] rv_s1;
	logic signed [PW-1:0] gu_s1;
	logic signed [PW-1:0] gv_s1;
	logic signed [PW-1:0] bu_s1;
	logic last_of_word_s1;
	logic frame_end_s1;

	logic signed [SW-1:0] sum_r;
	logic signed [SW-1:0] sum_g;
	logic signed [SW-1:0] sum_b;

	logic valid_s2;
	pyx_pkg::out_item_t data_s2;

	always_comb begin
		case (cfg.matrix_standard)
			pyx_pkg::STD_FULL: cs = SET_FULL;
			pyx_pkg::STD_HDTV: cs = SET_HDTV;
			default: cs = SET_SDTV;
		endcase
	end

	assign en = ~valid_s2 | out_ready;
	assign pop = en & ~q_empty;

	assign yd = $signed({2'b00, head.y}) - $signed({5'b00000, cs.yoff});
	assign ud = $signed({1'b0, head.u}) - 9'sd128;
	assign vd = $signed({1'b0, head.v}) - 9'sd128;

	always_ff @(posedge clk) begin
		if (en) begin
			ty_s1 <= PW'(cs.y) * PW'(yd);
			rv_s1 <= PW'(cs.rv) * PW'(vd);
			gu_s1 <= PW'(cs.gu) * PW'(ud);
			gv_s1 <= PW'(cs.gv) * PW'(vd);
			bu_s1 <= PW'(cs.bu) * PW'(ud);
			last_of_word_s1 <= head.last_of_word;
			frame_end_s1 <= head.frame_end;
		end
	end

	assign sum_r = SW'(ty_s1) + SW'(rv_s1) + RND;
	assign sum_g = SW'(ty_s1) + SW'(gu_s1) + SW'(gv_s1) + RND;
	assign sum_b = SW'(ty_s1) + SW'(bu_s1) + RND;

	always_ff @(posedge clk) begin
		if (en) begin
			data_s2.blue <= clamp8(sum_b);
			data_s2.green <= clamp8(sum_g);
			data_s2.red <= clamp8(sum_r);
			data_s2.alpha <= 8'hFF;
			data_s2.last_of_word <= last_of_word_s1;
			data_s2.frame_end <= frame_end_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else if (en) begin
			valid_s1 <= ~q_empty;
			valid_s2 <= valid_s1;
		end
	end

	assign out_valid = valid_s2;
	assign out_data = data_s2;

endmodule

### src/packed_yuv_to_xbgr_pixels.sv
// Top level of the packed YUV to XBGR pixel converter: registers, front end, queue, back end.
// Depends on pyx_pkg, pyx_front, pyx_queue and pyx_back.
//
// Port group   Direction  Handshake           Beat
// in_*         input      in_valid/in_ready   one packed 4-byte YUV word
// out_*        output     out_valid/out_ready one B,G,R,A pixel
// cfg_*        input      cfg_wr_en only      one register write
//
// A YUY2 or UYVY word yields two pixel jobs at the front end, an AYUV word one.
// The back end delivers one pixel per cycle; the result port sets the rate.
// A pixel passes the front-end word register, a queue entry and the back-end product and pixel registers.
// A stalled result port fills the job queue, and then the front end stops taking words.
// Reset empties the pipeline and loads the SDTV matrix and YUY2 packing.
module packed_yuv_to_xbgr_pixels #(
	parameter int COEF_FRACTION_BITS = pyx_pkg::COEF_FRACTION_BITS_DEF,
	parameter int QUEUE_DEPTH = pyx_pkg::QUEUE_DEPTH_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  pyx_pkg::in_item_t                 in_data,
	output logic                              out_valid,
	input  logic                              out_ready,
	output pyx_pkg::out_item_t                out_data,
	input  logic                              cfg_wr_en,
	input  logic [pyx_pkg::CFG_INDEX_W-1:0]   cfg_index,
	input  logic [pyx_pkg::CFG_W-1:0]         cfg_wdata
);

	pyx_pkg::cfg_t cfg_q;
	logic q_full;
	logic q_empty;
	logic push;
	logic pop;
	pyx_pkg::pix_job_t push_job;
	pyx_pkg::pix_job_t head;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.matrix_standard <= pyx_pkg::MATRIX_STANDARD_RST;
			cfg_q.input_packing <= pyx_pkg::INPUT_PACKING_RST;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				pyx_pkg::REG_MATRIX_STANDARD: cfg_q.matrix_standard <= cfg_wdata;
				pyx_pkg::REG_INPUT_PACKING: cfg_q.input_packing <= cfg_wdata;
				default: cfg_q <= cfg_q;
			endcase
		end
	end

	pyx_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_data  (in_data),
		.q_full   (q_full),
		.push     (push),
		.job      (push_job)
	);

	pyx_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_job (push_job),
		.pop      (pop),
		.full     (q_full),
		.empty    (q_empty),
		.head     (head)
	);

	pyx_back #(
		.COEF_FRACTION_BITS (COEF_FRACTION_BITS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.q_empty   (q_empty),
		.head      (head),
		.pop       (pop),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

endmodule

### src/pyx_checker.sv
// Port-level checks for the packed YUV to XBGR converter, bound to the top level.
// Depends on pyx_pkg and the assertion macros header.
`include "packed_yuv_to_xbgr_pixels_macros.svh"

module pyx_checker (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              out_valid,
	input logic                              out_ready,
	input pyx_pkg::out_item_t                out_data
);

	`PYX_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_data), "result beat changed while stalled")
	`PYX_ASSERT_NOW(a_alpha_opaque, out_valid, out_data.alpha == 8'hFF, "alpha is not 255")
	`PYX_ASSERT_NOW(a_frame_end_last, out_valid && out_data.frame_end, out_data.last_of_word, "frame end on a pixel that does not close its word")
	`PYX_ASSERT_NEXT(a_pair_follows, out_valid && out_ready && !out_data.last_of_word, out_valid, "second pixel of a word did not follow")

endmodule

bind packed_yuv_to_xbgr_pixels pyx_checker u_pyx_checker (.*);

### bench/pyx_pixel_checker.sv
`timescale 1ns / 1ps
// Pixel checker for the packed YUV to XBGR converter: watches the word, pixel and register ports,
// predicts every pixel of each accepted word and compares it with what the block delivers.
// Depends on pyx_pkg for the beat types and register codes.
module pyx_pixel_checker (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic               in_ready,
	input  pyx_pkg::in_item_t  in_data,
	input  logic               out_valid,
	input  logic               out_ready,
	input  pyx_pkg::out_item_t out_data,
	input  logic               cfg_wr_en,
	input  logic [1:0]         cfg_index,
	input  logic [1:0]         cfg_wdata,
	output int                 fail_count,
	output int                 pending
);

	localparam int FRAC_BITS = 15;
	localparam int MAX_REPORTS = 10;

	// Y offset, then Y, V-to-R, U-to-G, V-to-G and U-to-B gains in thousandths.
	// The spare selector value falls back to the SDTV matrix.
	localparam int GAIN_MILLI [4][6] = '{
		'{0, 1000, 1400, -343, -711, 1765},
		'{16, 1164, 1596, -391, -813, 2018},
		'{16, 1164, 1793, -213, -533, 2112},
		'{16, 1164, 1596, -391, -813, 2018}
	};

	logic [1:0] cur_standard;
	logic [1:0] cur_packing;
	pyx_pkg::out_item_t expected_pixels [$];
	int         mismatches;

	function automatic longint fixed_gain(input int milli);
		longint mag;
		longint q;
		mag = (milli < 0) ? longint'(-milli) : longint'(milli);
		q = (mag * (64'sd1 <<< FRAC_BITS) + 64'sd500) / 64'sd1000;
		return (milli < 0) ? -q : q;
	endfunction

	function automatic logic [7:0] round_sat(input longint acc);
		longint t;
		t = acc + (64'sd1 <<< (FRAC_BITS - 1));
		if (t < 0)
			return 8'd0;
		t = t >>> FRAC_BITS;
		return (t > 255) ? 8'd255 : t[7:0];
	endfunction

	function automatic pyx_pkg::out_item_t yuv_to_pixel(input logic [7:0] y,
			input logic [7:0] u, input logic [7:0] v, input logic [1:0] standard,
			input logic last_px, input logic frame_px);
		pyx_pkg::out_item_t px;
		longint yd;
		longint ud;
		longint vd;
		longint ty;
		yd = longint'(y) - GAIN_MILLI[standard][0];
		ud = longint'(u) - 128;
		vd = longint'(v) - 128;
		ty = fixed_gain(GAIN_MILLI[standard][1]) * yd;
		px.red = round_sat(ty + fixed_gain(GAIN_MILLI[standard][2]) * vd);
		px.green = round_sat(ty + fixed_gain(GAIN_MILLI[standard][3]) * ud
			+ fixed_gain(GAIN_MILLI[standard][4]) * vd);
		px.blue = round_sat(ty + fixed_gain(GAIN_MILLI[standard][5]) * ud);
		px.alpha = 8'd255;
		px.last_of_word = last_px;
		px.frame_end = frame_px;
		return px;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		pyx_pkg::out_item_t want;
		if (!arst_n) begin
			cur_standard <= pyx_pkg::MATRIX_STANDARD_RST;
			cur_packing <= pyx_pkg::INPUT_PACKING_RST;
			expected_pixels.delete();
			fail_count <= 0;
			mismatches = 0;
			pending <= 0;
		end else begin
			if (cfg_wr_en) begin
				if (cfg_index == pyx_pkg::REG_MATRIX_STANDARD)
					cur_standard <= cfg_wdata;
				else if (cfg_index == pyx_pkg::REG_INPUT_PACKING)
					cur_packing <= cfg_wdata;
			end
			if (out_valid && out_ready) begin
				if (expected_pixels.size() == 0) begin
					mismatches++;
					if (mismatches <= MAX_REPORTS)
						$display("unexpected pixel b=%0d g=%0d r=%0d a=%0d low=%0b fe=%0b",
							out_data.blue, out_data.green, out_data.red, out_data.alpha,
							out_data.last_of_word, out_data.frame_end);
				end else begin
					want = expected_pixels.pop_front();
					if (want.blue !== out_data.blue || want.green !== out_data.green
							|| want.red !== out_data.red || want.alpha !== out_data.alpha
							|| want.last_of_word !== out_data.last_of_word
							|| want.frame_end !== out_data.frame_end) begin
						mismatches++;
						if (mismatches <= MAX_REPORTS)
							$display({"pixel mismatch: expected b=%0d g=%0d r=%0d a=%0d ",
								"low=%0b fe=%0b, got b=%0d g=%0d r=%0d a=%0d low=%0b fe=%0b"},
								want.blue, want.green, want.red, want.alpha,
								want.last_of_word, want.frame_end,
								out_data.blue, out_data.green, out_data.red, out_data.alpha,
								out_data.last_of_word, out_data.frame_end);
					end
				end
			end
			if (in_valid && in_ready) begin
				case (cur_packing)
					pyx_pkg::PACK_AYUV: begin
						expected_pixels.push_back(yuv_to_pixel(in_data.byte_2, in_data.byte_1,
							in_data.byte_0, cur_standard, 1'b1, in_data.last_in_frame));
					end
					pyx_pkg::PACK_UYVY: begin
						expected_pixels.push_back(yuv_to_pixel(in_data.byte_1, in_data.byte_0,
							in_data.byte_2, cur_standard, 1'b0, 1'b0));
						expected_pixels.push_back(yuv_to_pixel(in_data.byte_3, in_data.byte_0,
							in_data.byte_2, cur_standard, 1'b1, in_data.last_in_frame));
					end
					default: begin
						expected_pixels.push_back(yuv_to_pixel(in_data.byte_0, in_data.byte_1,
							in_data.byte_3, cur_standard, 1'b0, 1'b0));
						expected_pixels.push_back(yuv_to_pixel(in_data.byte_2, in_data.byte_1,
							in_data.byte_3, cur_standard, 1'b1, in_data.last_in_frame));
					end
				endcase
			end
			fail_count <= mismatches;
			pending <= expected_pixels.size();
		end
	end

endmodule

### bench/tb_top.sv
`timescale 1ns / 1ps
// Top of the converter testbench: clock, reset, word and register stimulus, pixel back-pressure.
// Depends on pyx_pkg, packed_yuv_to_xbgr_pixels and pyx_pixel_checker.
module tb_top;

	localparam int CYCLE_LIMIT = 600000;
	localparam int PHASES = 12;
	localparam int WORDS_PER_PHASE = 85;
	localparam int SETTLE_CYCLES = 8;
	localparam int HOLD_CYCLES = 300;
	localparam logic [1:0] STD_SPARE = 2'd3;
	localparam logic [1:0] PACK_SPARE = 2'd3;
	localparam logic [1:0] REG_UNUSED_A = 2'd2;
	localparam logic [1:0] REG_UNUSED_B = 2'd3;

	logic       clk;
	logic       arst_n;
	logic       in_valid;
	logic       in_ready;
	pyx_pkg::in_item_t  in_data;
	logic       out_valid;
	logic       out_ready;
	pyx_pkg::out_item_t out_data;
	logic       cfg_wr_en;
	logic [1:0] cfg_index;
	logic [1:0] cfg_wdata;
	int         fail_count;
	int         pending;
	int         cycles;
	int         hold_req;
	int         hold_done;
	bit         no_gaps;
	int         phase;
	int         n;
	int         rx_run;
	int         rx_gap;

	packed_yuv_to_xbgr_pixels DUT (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data(out_data),
		.cfg_wr_en(cfg_wr_en),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata)
	);

	pyx_pixel_checker u_checker (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data(out_data),
		.cfg_wr_en(cfg_wr_en),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata),
		.fail_count(fail_count),
		.pending(pending)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("status: fail");
			$finish;
		end
	end

	function automatic pyx_pkg::in_item_t mk_word(input logic [7:0] b0, input logic [7:0] b1,
			input logic [7:0] b2, input logic [7:0] b3, input logic last);
		pyx_pkg::in_item_t w;
		w.byte_0 = b0;
		w.byte_1 = b1;
		w.byte_2 = b2;
		w.byte_3 = b3;
		w.last_in_frame = last;
		return w;
	endfunction

	function automatic logic [7:0] pick_byte();
		if ($urandom_range(0, 99) < 70)
			return 8'($urandom_range(0, 255));
		case ($urandom_range(0, 5))
			0: return 8'd0;
			1: return 8'd255;
			2: return 8'd16;
			3: return 8'd235;
			4: return 8'd128;
			default: return 8'd240;
		endcase
	endfunction

	function automatic int next_gap();
		int r;
		r = $urandom_range(0, 99);
		if (no_gaps || r < 50)
			return 0;
		if (r < 88)
			return $urandom_range(1, 3);
		return $urandom_range(5, 30);
	endfunction

	task automatic send_word(input pyx_pkg::in_item_t w, input int gap);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= w;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic set_config(input logic [1:0] standard, input logic [1:0] packing,
			input bit stray);
		wait_drained();
		cfg_wr_en <= 1'b1;
		cfg_index <= pyx_pkg::REG_MATRIX_STANDARD;
		cfg_wdata <= standard;
		@(posedge clk);
		cfg_index <= pyx_pkg::REG_INPUT_PACKING;
		cfg_wdata <= packing;
		@(posedge clk);
		if (stray) begin
			cfg_index <= ($urandom_range(0, 1) != 0) ? REG_UNUSED_A : REG_UNUSED_B;
			cfg_wdata <= 2'($urandom_range(0, 3));
			@(posedge clk);
		end
		cfg_wr_en <= 1'b0;
	endtask

	initial begin
		out_ready = 1'b0;
		hold_done = 0;
		wait (arst_n);
		@(posedge clk);
		forever begin
			if (hold_done != hold_req) begin
				hold_done = hold_req;
				out_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end
			rx_run = ($urandom_range(0, 99) < 10) ? $urandom_range(40, 150)
				: $urandom_range(1, 8);
			out_ready <= 1'b1;
			repeat (rx_run) @(posedge clk);
			rx_gap = $urandom_range(0, 99);
			rx_gap = (rx_gap < 60) ? 0 : (rx_gap < 90) ? $urandom_range(1, 3)
				: $urandom_range(10, 40);
			if (rx_gap > 0) begin
				out_ready <= 1'b0;
				repeat (rx_gap) @(posedge clk);
			end
		end
	end

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		cfg_wr_en = 1'b0;
		cfg_index = pyx_pkg::REG_MATRIX_STANDARD;
		cfg_wdata = '0;
		hold_req = 0;
		no_gaps = 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset settings: SDTV matrix with YUY2 packing.
		send_word(mk_word(8'h00, 8'h00, 8'h00, 8'h00, 1'b0), 0);
		send_word(mk_word(8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b1), 0);
		send_word(mk_word(8'hFF, 8'h00, 8'h00, 8'hFF, 1'b0), 2);
		send_word(mk_word(8'h00, 8'hFF, 8'hFF, 8'h00, 1'b1), 0);
		send_word(mk_word(8'h10, 8'h80, 8'hEB, 8'h80, 1'b0), 0);

		set_config(pyx_pkg::STD_FULL, pyx_pkg::PACK_UYVY, 1'b0);
		send_word(mk_word(8'h80, 8'h00, 8'h80, 8'hFF, 1'b1), 0);
		send_word(mk_word(8'hFF, 8'hFF, 8'h00, 8'h00, 1'b0), 0);
		send_word(mk_word(8'h00, 8'hFF, 8'hFF, 8'h80, 1'b1), 1);

		set_config(pyx_pkg::STD_HDTV, pyx_pkg::PACK_AYUV, 1'b0);
		send_word(mk_word(8'hFF, 8'h00, 8'hFF, 8'h00, 1'b1), 0);
		send_word(mk_word(8'h00, 8'hFF, 8'h10, 8'hFF, 1'b0), 0);
		send_word(mk_word(8'h80, 8'h80, 8'hEB, 8'h5A, 1'b1), 0);

		// Spare codes for both selectors fall back to SDTV and YUY2.
		set_config(STD_SPARE, PACK_SPARE, 1'b0);
		send_word(mk_word(8'hEB, 8'hF0, 8'h10, 8'h10, 1'b1), 0);
		send_word(mk_word(8'h00, 8'h00, 8'hFF, 8'hFF, 1'b0), 0);

		// Writes to unused indexes must leave both registers alone.
		set_config(pyx_pkg::STD_FULL, pyx_pkg::PACK_AYUV, 1'b0);
		wait_drained();
		cfg_wr_en <= 1'b1;
		cfg_index <= REG_UNUSED_A;
		cfg_wdata <= pyx_pkg::STD_HDTV;
		@(posedge clk);
		cfg_index <= REG_UNUSED_B;
		cfg_wdata <= pyx_pkg::PACK_UYVY;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		send_word(mk_word(8'h00, 8'hFF, 8'hFF, 8'h00, 1'b1), 0);
		send_word(mk_word(8'hFF, 8'h00, 8'h00, 8'hFF, 1'b0), 0);

		for (phase = 0; phase < PHASES; phase++) begin
			set_config(2'(phase % 4), 2'((phase + phase / 4) % 4), $urandom_range(0, 3) == 0);
			no_gaps = (phase % 5 == 2);
			if (phase == 3 || phase == 8)
				hold_req++;
			for (n = 0; n < WORDS_PER_PHASE; n++) begin
				if (phase == 6 && n == WORDS_PER_PHASE / 2)
					wait_drained();
				send_word(mk_word(pick_byte(), pick_byte(), pick_byte(), pick_byte(),
					$urandom_range(0, 1)), next_gap());
			end
		end

		wait_drained();
		repeat (20) @(posedge clk);
		if (fail_count == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
